>>> sv/ssym_pkg.sv
// ----------------------------------------------------------------------------
// ssym_pkg
// Shared types and constants for the scoped symbol stack.
// ----------------------------------------------------------------------------
package ssym_pkg;

    localparam int unsigned DEPTH_DEF        = 64;
    localparam int unsigned LEXEME_BYTES_DEF = 8;

    localparam logic [2:0] FN_PUSH     = 3'd0;
    localparam logic [2:0] FN_POP      = 3'd1;
    localparam logic [2:0] FN_DROP     = 3'd2;
    localparam logic [2:0] FN_LOOK_CUR = 3'd3;
    localparam logic [2:0] FN_LOOK_ALL = 3'd4;
    localparam logic [2:0] FN_CLEAR    = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        OP_PUSH,
        OP_POP,
        OP_DROP,
        OP_LOOK_CUR,
        OP_LOOK_ALL,
        OP_CLEAR,
        OP_NOP
    } t_op_kind;

    typedef struct packed {
        t_op_kind    kind;
        logic [7:0]  sym;
        logic [63:0] lex;
        logic [3:0]  typ;
        logic [7:0]  scope;
    } t_op;

    typedef struct packed {
        logic [7:0]  sym;
        logic [63:0] lex;
        logic [3:0]  typ;
        logic [7:0]  scope;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CHECK
    } t_state;

endpackage

>>> sv/ssym_if.sv
// ----------------------------------------------------------------------------
// ssym_in_if / ssym_out_if
// Request and response channels of the scoped symbol stack.
// ----------------------------------------------------------------------------
interface ssym_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  func;
    logic [7:0]  symbol_code;
    logic [63:0] lexeme_text;
    logic [3:0]  entry_type;
    logic [7:0]  current_scope;

    modport source (output valid, func, symbol_code, lexeme_text, entry_type,
                    current_scope, input ready);
    modport sink   (input valid, func, symbol_code, lexeme_text, entry_type,
                    current_scope, output ready);
endinterface

interface ssym_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        found;
    logic [3:0]  found_type;
    logic [7:0]  popped_symbol;
    logic [63:0] popped_lexeme;
    logic        is_empty;

    modport source (output valid, status, found, found_type, popped_symbol,
                    popped_lexeme, is_empty, input ready);
    modport sink   (input valid, status, found, found_type, popped_symbol,
                    popped_lexeme, is_empty, output ready);
endinterface

>>> sv/ssym_front.sv
// ----------------------------------------------------------------------------
// ssym_front
// Accepts request words, trims the lexeme, decodes the function and queues
// the result in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module ssym_front #(
    parameter int unsigned LEXEME_BYTES = ssym_pkg::LEXEME_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    ssym_in_if.sink          i_req,
    output logic             o_op_valid,
    input  logic             i_op_ready,
    output ssym_pkg::t_op    o_op
);
    import ssym_pkg::*;

    t_op        r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_op        w_op;
    logic       w_push, w_pop;

    always_comb begin
        logic alive;
        alive        = 1'b1;
        w_op.lex     = '0;
        for (int i = 0; i < 8; i++) begin
            if (i < LEXEME_BYTES && alive && i_req.lexeme_text[8*i +: 8] != 8'd0) begin
                w_op.lex[8*i +: 8] = i_req.lexeme_text[8*i +: 8];
            end else begin
                alive = 1'b0;
            end
        end
        w_op.sym   = i_req.symbol_code;
        w_op.typ   = i_req.entry_type;
        w_op.scope = i_req.current_scope;
        case (i_req.func)
            FN_PUSH:     w_op.kind = OP_PUSH;
            FN_POP:      w_op.kind = OP_POP;
            FN_DROP:     w_op.kind = OP_DROP;
            FN_LOOK_CUR: w_op.kind = OP_LOOK_CUR;
            FN_LOOK_ALL: w_op.kind = OP_LOOK_ALL;
            FN_CLEAR:    w_op.kind = OP_CLEAR;
            default:     w_op.kind = OP_NOP;
        endcase
    end

    assign i_req.ready = (r_cnt != 2'd2);
    assign o_op_valid  = (r_cnt != 2'd0);
    assign o_op        = r_q[r_rp];
    assign w_push      = i_req.valid && i_req.ready;
    assign w_pop       = o_op_valid && i_op_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_op;
    end

endmodule

>>> sv/ssym_back.sv
// ----------------------------------------------------------------------------
// ssym_back
// Holds the stack memory, walks it from the top for pop, drop-scope and
// lookups, and registers one response word.
// ----------------------------------------------------------------------------
module ssym_back #(
    parameter int unsigned DEPTH = ssym_pkg::DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_op_valid,
    output logic          o_op_ready,
    input  ssym_pkg::t_op i_op,
    ssym_out_if.source    o_rsp
);
    import ssym_pkg::*;

    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned AW = $clog2(DEPTH);

    t_entry       r_mem [DEPTH];
    t_entry       r_rd;
    t_state       r_state, n_state;
    t_op          r_op, n_op;
    logic [CW-1:0] r_count, n_count, r_idx, n_idx;
    logic         r_out_valid, n_out_valid;
    logic [1:0]   r_status, n_status;
    logic         r_found, n_found, r_empty, n_empty;
    logic [3:0]   r_ftype, n_ftype;
    logic [7:0]   r_psym, n_psym;
    logic [63:0]  r_plex, n_plex;
    logic         take, done, mem_we;
    logic [AW-1:0] rd_addr;
    t_entry       wdata;

    assign rd_addr = AW'(r_idx - CW'(1));
    assign wdata   = '{sym: i_op.sym, lex: i_op.lex, typ: i_op.typ, scope: i_op.scope};

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_count     = r_count;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_status    = r_status;
        n_found     = r_found;
        n_ftype     = r_ftype;
        n_psym      = r_psym;
        n_plex      = r_plex;
        n_empty     = r_empty;
        take        = 1'b0;
        done        = 1'b0;
        mem_we      = 1'b0;
        if (r_out_valid && o_rsp.ready) n_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_op_valid && !r_out_valid) begin
                    take     = 1'b1;
                    n_op     = i_op;
                    n_status = ST_OK;
                    n_found  = 1'b0;
                    n_ftype  = 4'd0;
                    n_psym   = 8'd0;
                    n_plex   = 64'd0;
                    case (i_op.kind)
                        OP_PUSH: begin
                            if (r_count == CW'(DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                mem_we  = 1'b1;
                                n_count = r_count + CW'(1);
                            end
                            done = 1'b1;
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                            done    = 1'b1;
                        end
                        OP_POP, OP_DROP, OP_LOOK_CUR, OP_LOOK_ALL: begin
                            if (r_count == '0) begin
                                if (i_op.kind == OP_POP) n_status = ST_EMPTY;
                                done = 1'b1;
                            end else begin
                                n_idx   = r_count;
                                n_state = S_READ;
                            end
                        end
                        default: done = 1'b1;
                    endcase
                end
            end
            S_READ: n_state = S_CHECK;
            S_CHECK: begin
                case (r_op.kind)
                    OP_POP: begin
                        n_count = r_idx - CW'(1);
                        n_psym  = r_rd.sym;
                        n_plex  = r_rd.lex;
                        done    = 1'b1;
                    end
                    OP_DROP: begin
                        if (r_rd.scope == r_op.scope) begin
                            n_count = r_idx - CW'(1);
                            if (r_idx == CW'(1)) begin
                                done = 1'b1;
                            end else begin
                                n_idx   = r_idx - CW'(1);
                                n_state = S_READ;
                            end
                        end else begin
                            done = 1'b1;
                        end
                    end
                    default: begin
                        if (r_op.kind == OP_LOOK_CUR && r_rd.scope != r_op.scope) begin
                            done = 1'b1;
                        end else if (r_rd.sym == r_op.sym && r_rd.lex == r_op.lex) begin
                            n_found = 1'b1;
                            n_ftype = r_rd.typ;
                            done    = 1'b1;
                        end else if (r_idx == CW'(1)) begin
                            done = 1'b1;
                        end else begin
                            n_idx   = r_idx - CW'(1);
                            n_state = S_READ;
                        end
                    end
                endcase
            end
            default: n_state = S_IDLE;
        endcase
        if (done) begin
            n_state     = S_IDLE;
            n_out_valid = 1'b1;
            n_empty     = (n_count == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_status <= n_status;
        r_found  <= n_found;
        r_ftype  <= n_ftype;
        r_psym   <= n_psym;
        r_plex   <= n_plex;
        r_empty  <= n_empty;
    end

    // stack memory: push writes the slot above the top, scans read one slot
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[AW'(r_count)] <= wdata;
        r_rd <= r_mem[rd_addr];
    end

    assign o_op_ready          = take;
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_status;
    assign o_rsp.found         = r_found;
    assign o_rsp.found_type    = r_ftype;
    assign o_rsp.popped_symbol = r_psym;
    assign o_rsp.popped_lexeme = r_plex;
    assign o_rsp.is_empty      = r_empty;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fill count above depth");
    a_busy_no_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !r_out_valid)
        else $error("response pending during scan");
    a_scan_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_idx != '0) && (r_idx <= r_count))
        else $error("scan index out of range");
    a_push_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_op.kind == OP_PUSH && r_count != CW'(DEPTH))
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("push did not grow stack");

endmodule

>>> sv/scoped_symbol_stack.sv
// ----------------------------------------------------------------------------
// scoped_symbol_stack
// Bounded stack of scoped symbol entries with pop, drop-scope and lookups.
// ----------------------------------------------------------------------------
// Push, clear and unknown functions need no scan: the back end registers
// their response word as it takes the request from the queue. Pop,
// drop-scope and lookups walk the stack from the top, each visited entry
// getting a registered memory read (S_READ), then a compare (S_CHECK). The
// back end takes no new word while its response word waits, so items
// complete one at a time. A two-word queue after the input lets new
// requests be taken while the back end works or a response waits.
module scoped_symbol_stack #(
    parameter int unsigned DEPTH        = ssym_pkg::DEPTH_DEF,
    parameter int unsigned LEXEME_BYTES = ssym_pkg::LEXEME_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ssym_in_if.sink     i_req,
    ssym_out_if.source  o_rsp
);
    import ssym_pkg::*;

    logic op_valid, op_ready;
    t_op  op;

    ssym_front #(.LEXEME_BYTES(LEXEME_BYTES)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .o_op_valid (op_valid),
        .i_op_ready (op_ready),
        .o_op       (op)
    );

    ssym_back #(.DEPTH(DEPTH)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (op_valid),
        .o_op_ready (op_ready),
        .i_op       (op),
        .o_rsp      (o_rsp)
    );

endmodule
